>>> rtl/nctx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nctx_pkg
// Shared constants, codes and widths for the order-k nucleotide context model.
// ----------------------------------------------------------------------------
package nctx_pkg;

  // Table geometry
  localparam int MAX_ORDER   = 8;
  localparam int COUNT_BITS  = 16;
  localparam int CTX_W       = 2 * MAX_ORDER;
  localparam int TABLE_DEPTH = 1 << CTX_W;
  localparam int ENTRY_W     = 4 * COUNT_BITS;

  // Register and field widths
  localparam int ORDER_W    = 4;
  localparam int ALPHA_W    = 8;
  localparam int MAXC_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SYM_W      = 2;
  localparam int FREQ_W     = 24;
  localparam int TOTAL_W    = 26;
  localparam int PROD_W     = ALPHA_W + COUNT_BITS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_DEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 2'd2;

  // Register reset values
  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 8'd1;
  localparam logic [MAXC_W-1:0]  MAXC_RST  = 16'hFFFF;

  // Commands
  localparam logic CMD_SYMBOL  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

endpackage : nctx_pkg
`default_nettype wire

>>> rtl/nctx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nctx_in_if / nctx_out_if
// Valid/ready channels for symbol transactions and estimate transactions.
// ----------------------------------------------------------------------------
interface nctx_in_if;
  import nctx_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface : nctx_in_if

interface nctx_out_if;
  import nctx_pkg::*;
  logic               valid;
  logic               ready;
  logic [FREQ_W-1:0]  freq_a;
  logic [FREQ_W-1:0]  freq_c;
  logic [FREQ_W-1:0]  freq_g;
  logic [FREQ_W-1:0]  freq_t;
  logic [TOTAL_W-1:0] freq_total;

  modport source (output valid, output freq_a, output freq_c, output freq_g,
                  output freq_t, output freq_total, input ready);
  modport sink   (input valid, input freq_a, input freq_c, input freq_g,
                  input freq_t, input freq_total, output ready);
endinterface : nctx_out_if
`default_nettype wire

>>> rtl/nctx_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nctx_ram
// Generic single-write, single-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module nctx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : nctx_ram
`default_nettype wire

>>> rtl/nucleotide_context_model.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nucleotide_context_model
// Order-k context model: per-context symbol counters in one table RAM,
// estimates 1 + alpha_den * count, halving all counts when the bumped count reaches a nonzero max_count.
// ----------------------------------------------------------------------------
// Pipeline: an accepted symbol and its table read enter stage 1; write-back
//   and the output register load follow when stage 1 advances.
// Throughput: one transaction per cycle unless the output stalls; a repeated
//   context is served by forwarding the write that lands on the same edge as
//   the table read.
// Reset: after rst_n the table RAM is cleared one entry per cycle; during the
//   pass no input transaction is taken; config stays open.
// ----------------------------------------------------------------------------
module nucleotide_context_model
  import nctx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  nctx_in_if.sink                    in_chan,
  nctx_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [ORDER_W-1:0] MAX_ORDER_C = ORDER_W'(MAX_ORDER);
  localparam logic [CTX_W-1:0]   LAST_ADDR   = {CTX_W{1'b1}};

  // Configuration registers
  logic [ORDER_W-1:0] order_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [MAXC_W-1:0]  maxc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RST;
      alpha_r <= ALPHA_RST;
      maxc_r  <= MAXC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONTEXT_ORDER: order_r <= cfg_data[ORDER_W-1:0];
        REG_ALPHA_DEN:     alpha_r <= cfg_data[ALPHA_W-1:0];
        REG_MAX_COUNT:     maxc_r  <= cfg_data[MAXC_W-1:0];
        default:           ;
      endcase
    end
  end

  // Clearing pass state
  logic             clr_r;
  logic [CTX_W-1:0] clr_addr_r;

  // Stage 1 (table data back from RAM)
  logic               s1_valid_r;
  logic [SYM_W-1:0]   s1_sym_r;
  logic [CTX_W-1:0]   s1_addr_r;
  logic               s1_fwd_r;
  logic [ENTRY_W-1:0] s1_fwd_data_r;
  logic               s1_adv;

  // Output register
  logic               out_valid_r;
  logic [FREQ_W-1:0]  freq_r [4];
  logic [TOTAL_W-1:0] total_r;

  // Context history
  logic [CTX_W-1:0] ctx_r;

  // RAM ports
  logic               ram_we;
  logic [CTX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               in_accept;
  logic               sym_accept;
  logic [ORDER_W-1:0] order_eff;
  logic [CTX_W-1:0]   ctx_mask;
  logic [CTX_W-1:0]   ctx_cur;
  logic [CTX_W-1:0]   ctx_nxt;

  logic [ENTRY_W-1:0]    entry;
  logic [COUNT_BITS-1:0] cnt [4];
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  halve;
  logic [ENTRY_W-1:0]    entry_nxt;
  logic [FREQ_W-1:0]     freq_nxt [4];
  logic [TOTAL_W-1:0]    total_nxt;

  // Handshake
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !clr_r && (!s1_valid_r || s1_adv);
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign sym_accept    = in_accept && (in_chan.command == CMD_SYMBOL);

  // Context mask for the effective order (0 acts as 1, clipped at the max)
  always_comb begin
    if (order_r == '0) begin
      order_eff = ORDER_W'(1);
    end else if (order_r > MAX_ORDER_C) begin
      order_eff = MAX_ORDER_C;
    end else begin
      order_eff = order_r;
    end
    ctx_mask = ~({CTX_W{1'b1}} << {order_eff, 1'b0});
    ctx_cur  = ctx_r & ctx_mask;
    ctx_nxt  = {ctx_cur[CTX_W-SYM_W-1:0], in_chan.symbol} & ctx_mask;
  end

  // Context history register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (in_accept) begin
      if (in_chan.command == CMD_RESTART) begin
        ctx_r <= '0;
      end else begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_r <= 1'b0;
      end
    end
  end

  // RAM port muxing: clearing pass or stage-1 write-back
  always_comb begin
    ram_re = sym_accept;
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_r && s1_adv;
      ram_waddr = s1_addr_r;
      ram_wdata = entry_nxt;
    end
  end

  nctx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ctx_cur),
    .rdata (ram_rdata)
  );

  // Stage 1 control; note a write to the address being read on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (sym_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_accept) begin
      s1_sym_r      <= in_chan.symbol;
      s1_addr_r     <= ctx_cur;
      s1_fwd_r      <= ram_we && (ram_waddr == ctx_cur);
      s1_fwd_data_r <= ram_wdata;
    end
  end

  // Stage 1 datapath: counters, estimates, update with optional halving
  always_comb begin
    entry = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
    for (int j = 0; j < 4; j++) begin
      cnt[j] = entry[j*COUNT_BITS +: COUNT_BITS];
    end
    cnt_inc = cnt[s1_sym_r] + 1'b1;
    halve   = (maxc_r != '0) && (MAXC_W'(cnt_inc) == maxc_r);
    total_nxt = '0;
    for (int j = 0; j < 4; j++) begin
      freq_nxt[j] = FREQ_W'(PROD_W'(alpha_r) * PROD_W'(cnt[j])) + FREQ_W'(1);
      total_nxt   = total_nxt + TOTAL_W'(freq_nxt[j]);
      if (SYM_W'(j) == s1_sym_r) begin
        entry_nxt[j*COUNT_BITS +: COUNT_BITS] = halve ? (cnt_inc >> 1) : cnt_inc;
      end else begin
        entry_nxt[j*COUNT_BITS +: COUNT_BITS] = halve ? (cnt[j] >> 1) : cnt[j];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      for (int j = 0; j < 4; j++) begin
        freq_r[j] <= freq_nxt[j];
      end
      total_r <= total_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.freq_a     = freq_r[0];
  assign out_chan.freq_c     = freq_r[1];
  assign out_chan.freq_g     = freq_r[2];
  assign out_chan.freq_t     = freq_r[3];
  assign out_chan.freq_total = total_r;

  // Checks
  a_no_item_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !s1_valid_r && !out_valid_r)
    else $error("item in flight during table clearing pass");

  a_fwd_same_addr : assert property (@(posedge clk) disable iff (!rst_n)
    sym_accept && ram_we && (ram_waddr == ctx_cur) |=> s1_fwd_r)
    else $error("same-entry write not forwarded to following read");

  a_total_sum : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> total_r == (TOTAL_W'(freq_r[0]) + TOTAL_W'(freq_r[1])
                              + TOTAL_W'(freq_r[2]) + TOTAL_W'(freq_r[3])))
    else $error("total does not match the four estimates");

  a_stall_holds_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_addr_r) && !$past(ram_we))
    else $error("stage 1 lost or wrote back while stalled");

endmodule : nucleotide_context_model
`default_nettype wire

>>> tb/nucleotide_context_model_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_context_model_tb
// Drives symbol and restart transactions into the order-k context model with
// random source gaps and sink back-pressure. A scoreboard class keeps its own
// copy of the count table, context history and registers, predicts the four
// estimates and their total for every accepted symbol, and compares each
// estimate transaction field by field. Covers the register extremes,
// out-of-range orders, zero alpha, halving and a long back-to-back stretch
// on one context.
// ----------------------------------------------------------------------------
module nucleotide_context_model_tb;
  import nctx_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 215;
  localparam int HAMMER_ITEMS  = 200;
  localparam int REPORT_CAP    = 40;

  // Index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [SYM_W-1:0] {NUC_A, NUC_C, NUC_G, NUC_T} nuc_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  a;
    logic [FREQ_W-1:0]  c;
    logic [FREQ_W-1:0]  g;
    logic [FREQ_W-1:0]  t;
    logic [TOTAL_W-1:0] total;
  } estimate_t;

  // Count table predictor and store of expected estimates
  class estimate_scoreboard;
    bit [ENTRY_W-1:0]  counts [TABLE_DEPTH];
    bit [CTX_W-1:0]    history;
    bit [ORDER_W-1:0]  order_reg;
    bit [ALPHA_W-1:0]  alpha_reg;
    bit [MAXC_W-1:0]   maxc_reg;
    estimate_t         expected_q[$];
    int                errors;

    function new();
      history   = '0;
      order_reg = ORDER_RST;
      alpha_reg = ALPHA_RST;
      maxc_reg  = MAXC_RST;
      errors    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CONTEXT_ORDER: order_reg = data[ORDER_W-1:0];
        REG_ALPHA_DEN:     alpha_reg = data[ALPHA_W-1:0];
        REG_MAX_COUNT:     maxc_reg  = data[MAXC_W-1:0];
        default: ;
      endcase
    endfunction

    // Order 0 behaves as 1, anything above MAX_ORDER as MAX_ORDER
    function bit [CTX_W-1:0] context_mask();
      int        k;
      bit [31:0] m;
      k = int'(order_reg);
      if (k == 0) k = 1;
      if (k > MAX_ORDER) k = MAX_ORDER;
      m = (32'd1 << (2 * k)) - 32'd1;
      return m[CTX_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic cmd, logic [SYM_W-1:0] sym);
      bit [CTX_W-1:0]      mask;
      bit [CTX_W-1:0]      ctx;
      bit [ENTRY_W-1:0]    entry;
      bit [COUNT_BITS-1:0] bumped;
      bit [31:0]           f;
      bit [31:0]           sum;
      bit [FREQ_W-1:0]     fr [4];
      estimate_t           e;
      int                  j;
      // restart clears history only, no estimate
      if (cmd == CMD_RESTART) begin
        history = '0;
        return;
      end
      mask  = context_mask();
      ctx   = history & mask;
      entry = counts[ctx];
      sum   = '0;
      for (j = 0; j < 4; j++) begin
        f     = 32'd1 + alpha_reg * entry[j*COUNT_BITS +: COUNT_BITS];
        fr[j] = f[FREQ_W-1:0];
        sum   = sum + f;
      end
      e.a     = fr[0];
      e.c     = fr[1];
      e.g     = fr[2];
      e.t     = fr[3];
      e.total = sum[TOTAL_W-1:0];
      expected_q.push_back(e);
      // bump, wrap at counter width, halve all four on reaching max_count
      bumped = entry[sym*COUNT_BITS +: COUNT_BITS] + 1'b1;
      entry[sym*COUNT_BITS +: COUNT_BITS] = bumped;
      if (maxc_reg != '0 && bumped == maxc_reg) begin
        for (j = 0; j < 4; j++)
          entry[j*COUNT_BITS +: COUNT_BITS] = entry[j*COUNT_BITS +: COUNT_BITS] >> 1;
      end
      counts[ctx] = entry;
      history     = ((ctx << 2) | sym) & mask;
    endfunction

    task report(string msg);
      errors++;
      // keep the log bounded on a badly broken design
      if (errors <= REPORT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(estimate_t got);
      estimate_t want;
      if (expected_q.size() == 0) begin
        report("estimate transaction with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      if (got.a !== want.a)
        report($sformatf("freq_a got %0d want %0d", got.a, want.a));
      if (got.c !== want.c)
        report($sformatf("freq_c got %0d want %0d", got.c, want.c));
      if (got.g !== want.g)
        report($sformatf("freq_g got %0d want %0d", got.g, want.g));
      if (got.t !== want.t)
        report($sformatf("freq_t got %0d want %0d", got.t, want.t));
      if (got.total !== want.total)
        report($sformatf("freq_total got %0d want %0d", got.total, want.total));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    idle_on;
  bit                    stall_on;
  int                    cycle_count = 0;
  estimate_t             seen;
  estimate_scoreboard    sb;

  nctx_in_if  sym_ch ();
  nctx_out_if est_ch ();

  nucleotide_context_model dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (sym_ch),
    .out_chan  (est_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Sink back-pressure
  always @(posedge clk) begin
    if (stall_on) est_ch.ready <= ($urandom_range(0, 99) >= 20);
    else est_ch.ready <= 1'b1;
  end

  // Monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (est_ch.valid && est_ch.ready) begin
        seen.a     = est_ch.freq_a;
        seen.c     = est_ch.freq_c;
        seen.g     = est_ch.freq_g;
        seen.t     = est_ch.freq_t;
        seen.total = est_ch.freq_total;
        sb.check_result(seen);
      end
      if (sym_ch.valid && sym_ch.ready) sb.note_input(sym_ch.command, sym_ch.symbol);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One transaction; valid is left high for the next call to reuse
  task automatic send_item(input logic cmd, input logic [SYM_W-1:0] sym);
    while (idle_on && $urandom_range(0, 99) < 20) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid   <= 1'b1;
    sym_ch.command <= cmd;
    sym_ch.symbol  <= sym;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Program all registers, junk in the unused upper data bits
  task automatic apply_settings(input logic [ORDER_W-1:0] order,
                                input logic [ALPHA_W-1:0] alpha,
                                input logic [MAXC_W-1:0]  maxc);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[ORDER_W-1:0] = order;
    write_reg(REG_CONTEXT_ORDER, d);
    d = CFG_DATA_W'($urandom);
    d[ALPHA_W-1:0] = alpha;
    write_reg(REG_ALPHA_DEN, d);
    write_reg(REG_MAX_COUNT, maxc);
    d = CFG_DATA_W'($urandom);
    write_reg(REG_SPARE, d);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected estimate, then let the pipeline settle
  task automatic drain();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                    phase;
    int                    sent;
    logic [SYM_W-1:0]      prev_sym;
    logic [ORDER_W-1:0]    order;
    logic [ALPHA_W-1:0]    alpha;
    logic [MAXC_W-1:0]     maxc;

    sb             = new();
    rst_n          = 1'b0;
    sym_ch.valid   = 1'b0;
    sym_ch.command = CMD_SYMBOL;
    sym_ch.symbol  = NUC_A;
    est_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_CONTEXT_ORDER;
    cfg_data       = '0;
    idle_on        = 1'b1;
    stall_on       = 1'b1;
    prev_sym       = NUC_A;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: all symbols, restart, repeated context back to back
    send_item(CMD_SYMBOL, NUC_A);
    send_item(CMD_SYMBOL, NUC_C);
    send_item(CMD_SYMBOL, NUC_G);
    send_item(CMD_SYMBOL, NUC_T);
    send_item(CMD_RESTART, NUC_T);
    repeat (3) send_item(CMD_SYMBOL, NUC_A);
    drain();

    // Order 0 acts as 1, zero alpha, halving on every bump
    apply_settings(4'd0, 8'd0, 16'd1);
    send_item(CMD_SYMBOL, NUC_A);
    send_item(CMD_SYMBOL, NUC_A);
    send_item(CMD_SYMBOL, NUC_C);
    send_item(CMD_SYMBOL, NUC_G);
    send_item(CMD_SYMBOL, NUC_T);
    send_item(CMD_SYMBOL, NUC_T);
    send_item(CMD_RESTART, NUC_A);
    drain();

    // Order above range acts as MAX_ORDER, largest alpha, halving at 2
    apply_settings(4'd15, 8'd255, 16'd2);
    repeat (4) send_item(CMD_SYMBOL, NUC_A);
    send_item(CMD_RESTART, NUC_C);
    send_item(CMD_SYMBOL, NUC_A);
    send_item(CMD_SYMBOL, NUC_A);
    send_item(CMD_SYMBOL, NUC_T);
    drain();

    // Long stretch with no gaps or stalls, one context hammered back to back
    idle_on  = 1'b0;
    stall_on = 1'b0;
    apply_settings(4'd1, 8'd255, 16'd0);
    send_item(CMD_RESTART, NUC_G);
    repeat (HAMMER_ITEMS) begin
      if ($urandom_range(0, 63) == 0) send_item(CMD_RESTART, SYM_W'($urandom_range(0, 3)));
      else send_item(CMD_SYMBOL, NUC_A);
    end
    drain();
    idle_on  = 1'b1;
    stall_on = 1'b1;

    // Random phases, each with its own settings; order changes mid-stream
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          order = 4'd1;
          alpha = 8'd255;
          maxc  = 16'd3;
        end
        1: begin
          order = 4'd8;
          alpha = 8'd1;
          maxc  = 16'hFFFF;
        end
        2: begin
          order = 4'd15;
          alpha = 8'd0;
          maxc  = 16'd0;
        end
        3: begin
          order = 4'd2;
          alpha = ALPHA_W'($urandom_range(1, 254));
          maxc  = MAXC_W'($urandom_range(2, 40));
        end
        4: begin
          order = 4'd3;
          alpha = ALPHA_W'($urandom_range(0, 255));
          maxc  = 16'd1;
        end
        default: begin
          order = ORDER_W'($urandom_range(0, 15));
          alpha = ALPHA_W'($urandom_range(0, 255));
          maxc  = MAXC_W'($urandom_range(0, 65535));
        end
      endcase
      apply_settings(order, alpha, maxc);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 24) == 0) begin
          send_item(CMD_RESTART, SYM_W'($urandom_range(0, 3)));
        end else begin
          // repeats keep contexts recurring so counts build up
          if ($urandom_range(0, 9) >= 3) prev_sym = SYM_W'($urandom_range(0, 3));
          send_item(CMD_SYMBOL, prev_sym);
          sent++;
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : nucleotide_context_model_tb
